// ----- rtl/core/rspg_pkg.sv -----
`default_nettype none

package rspg_pkg;

  // Input item kinds.
  localparam logic [1:0] ModeTick = 2'd0;
  localparam logic [1:0] ModeSet  = 2'd1;
  localparam logic [1:0] ModeAck  = 2'd2;

  // LED state codes.
  localparam logic [3:0] StOff        = 4'd0;
  localparam logic [3:0] StOk         = 4'd1;
  localparam logic [3:0] StAp         = 4'd2;
  localparam logic [3:0] StWatering   = 4'd3;
  localparam logic [3:0] StFailsafe   = 4'd4;
  localparam logic [3:0] StBoot       = 4'd5;
  localparam logic [3:0] StSleepSoon  = 4'd6;
  localparam logic [3:0] StConnecting = 4'd7;
  localparam logic [3:0] StWarning    = 4'd8;
  localparam logic [3:0] StCritical   = 4'd9;
  localparam logic [3:0] StAckFlash   = 4'd10;

  // Millisecond counters saturate here.
  localparam logic [9:0] MsMax = 10'd1023;

  // Flash timing: 100 ms phases, done after six of them.
  localparam logic [9:0] FlashPhase1 = 10'd100;
  localparam logic [9:0] FlashPhase2 = 10'd200;
  localparam logic [9:0] FlashPhase3 = 10'd300;
  localparam logic [9:0] FlashPhase4 = 10'd400;
  localparam logic [9:0] FlashPhase5 = 10'd500;
  localparam logic [9:0] FlashEnd    = 10'd600;

  // Animation periods (update once the counter passes the limit).
  localparam logic [9:0] BreathLimit     = 10'd20;
  localparam logic [9:0] BlinkConnLimit  = 10'd500;
  localparam logic [9:0] BlinkWarnLimit  = 10'd1000;
  localparam logic [9:0] BlinkCritLimit  = 10'd200;

  // Breathing range and step.
  localparam logic signed [8:0] BreathStep = 9'sd3;
  localparam logic signed [8:0] BreathHigh = 9'sd80;
  localparam logic signed [8:0] BreathLow  = 9'sd5;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  localparam rgb_t ColorOff      = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
  localparam rgb_t ColorOk       = '{r: 8'd0,   g: 8'd80,  b: 8'd0};
  localparam rgb_t ColorAp       = '{r: 8'd0,   g: 8'd0,   b: 8'd120};
  localparam rgb_t ColorWatering = '{r: 8'd0,   g: 8'd120, b: 8'd120};
  localparam rgb_t ColorFailsafe = '{r: 8'd180, g: 8'd0,   b: 8'd0};
  localparam rgb_t ColorBoot     = '{r: 8'd60,  g: 8'd60,  b: 8'd60};
  localparam rgb_t ColorFlash    = '{r: 8'd120, g: 8'd120, b: 8'd120};
  localparam rgb_t ColorConn     = '{r: 8'd0,   g: 8'd0,   b: 8'd120};
  localparam rgb_t ColorWarn     = '{r: 8'd180, g: 8'd120, b: 8'd0};
  localparam rgb_t ColorCrit     = '{r: 8'd255, g: 8'd0,   b: 8'd0};

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] state_code;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] current_state;
  } out_t;

endpackage

`default_nettype wire

// ----- rtl/core/rgb_status_pattern_generator.sv -----
`default_nettype none

// Status LED pattern generator. Each input transaction (a 1 ms tick, a
// set-state command or a button acknowledge) yields exactly one result
// transaction carrying the red, green and blue duty levels and the state
// code after that item (10 while the acknowledge flash runs). The state
// registers and the result register update at the edge that accepts an
// item, so a new item is accepted every cycle as long as the result
// register is empty or being drained in the same cycle.
// Set-state commands are ignored while the flash runs, as are unknown
// state codes; the unused mode code only repeats the current outputs.
module rgb_status_pattern_generator (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire rspg_pkg::in_t  in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output rspg_pkg::out_t    out_data_o
);

  logic          accept;

  logic [3:0]    led_mode_q, led_mode_d;
  logic [3:0]    saved_mode_q, saved_mode_d;
  logic          effect_on_q, effect_on_d;
  logic [9:0]    effect_ms_q, effect_ms_d;
  logic [9:0]    since_q, since_d;
  logic          blink_lit_q, blink_lit_d;
  logic [6:0]    breath_q, breath_d;
  logic          rising_q, rising_d;
  rspg_pkg::rgb_t color_q, color_d;

  logic           out_valid_q;
  rspg_pkg::out_t out_q;

  // Handshake: take an item unless the held result cannot leave.
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Blink period and lit colour for the current state.
  logic [9:0]     blink_limit;
  rspg_pkg::rgb_t blink_color;
  logic           blink_mode;

  always_comb begin
    blink_limit = rspg_pkg::BlinkConnLimit;
    blink_color = rspg_pkg::ColorConn;
    blink_mode  = 1'b0;
    case (led_mode_q)
      rspg_pkg::StConnecting: begin
        blink_limit = rspg_pkg::BlinkConnLimit;
        blink_color = rspg_pkg::ColorConn;
        blink_mode  = 1'b1;
      end
      rspg_pkg::StWarning: begin
        blink_limit = rspg_pkg::BlinkWarnLimit;
        blink_color = rspg_pkg::ColorWarn;
        blink_mode  = 1'b1;
      end
      rspg_pkg::StCritical: begin
        blink_limit = rspg_pkg::BlinkCritLimit;
        blink_color = rspg_pkg::ColorCrit;
        blink_mode  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Next state and result for one item.
  always_comb begin
    logic [9:0]        since_inc;
    logic [9:0]        effect_inc;
    logic signed [8:0] lvl;
    logic              lvl_rising;
    logic              enter;
    logic [3:0]        enter_code;
    logic              flash_dark;

    led_mode_d   = led_mode_q;
    saved_mode_d = saved_mode_q;
    effect_on_d  = effect_on_q;
    effect_ms_d  = effect_ms_q;
    since_d      = since_q;
    blink_lit_d  = blink_lit_q;
    breath_d     = breath_q;
    rising_d     = rising_q;
    color_d      = color_q;
    enter        = 1'b0;
    enter_code   = led_mode_q;

    since_inc  = (since_q != rspg_pkg::MsMax) ? since_q + 10'd1 : since_q;
    effect_inc = (effect_ms_q != rspg_pkg::MsMax) ? effect_ms_q + 10'd1 : effect_ms_q;

    // Odd 100 ms phases of the flash are dark.
    flash_dark = ((effect_inc >= rspg_pkg::FlashPhase1) && (effect_inc < rspg_pkg::FlashPhase2))
              || ((effect_inc >= rspg_pkg::FlashPhase3) && (effect_inc < rspg_pkg::FlashPhase4))
              || ((effect_inc >= rspg_pkg::FlashPhase5) && (effect_inc < rspg_pkg::FlashEnd));

    // Breathing step with clamping at both ends.
    lvl = $signed({2'b00, breath_q}) + (rising_q ? rspg_pkg::BreathStep
                                                 : -rspg_pkg::BreathStep);
    lvl_rising = rising_q;
    if (lvl >= rspg_pkg::BreathHigh) begin
      lvl        = rspg_pkg::BreathHigh;
      lvl_rising = 1'b0;
    end
    if (lvl <= rspg_pkg::BreathLow) begin
      lvl        = rspg_pkg::BreathLow;
      lvl_rising = 1'b1;
    end

    case (in_data_i.mode)
      rspg_pkg::ModeTick: begin
        since_d = since_inc;
        if (effect_on_q) begin
          effect_ms_d = effect_inc;
          if (effect_inc >= rspg_pkg::FlashEnd) begin
            effect_on_d = 1'b0;
            enter       = 1'b1;
            enter_code  = saved_mode_q;
          end else if (flash_dark) begin
            color_d = rspg_pkg::ColorOff;
          end else begin
            color_d = rspg_pkg::ColorFlash;
          end
        end else if (led_mode_q == rspg_pkg::StSleepSoon) begin
          if (since_inc > rspg_pkg::BreathLimit) begin
            since_d  = '0;
            breath_d = lvl[6:0];
            rising_d = lvl_rising;
            color_d  = '{r: 8'd0, g: {1'b0, lvl[6:0]}, b: 8'd0};
          end
        end else if (blink_mode) begin
          if (since_inc > blink_limit) begin
            since_d     = '0;
            blink_lit_d = ~blink_lit_q;
            color_d     = blink_lit_q ? rspg_pkg::ColorOff : blink_color;
          end
        end
      end
      rspg_pkg::ModeSet: begin
        if (!effect_on_q && (in_data_i.state_code inside {[rspg_pkg::StOff:rspg_pkg::StCritical]}))
        begin
          enter      = 1'b1;
          enter_code = in_data_i.state_code;
        end
      end
      rspg_pkg::ModeAck: begin
        if (!effect_on_q) begin
          saved_mode_d = led_mode_q;
        end
        led_mode_d  = rspg_pkg::StAckFlash;
        effect_on_d = 1'b1;
        effect_ms_d = '0;
      end
      default: begin
      end
    endcase

    // Entering resets animations; Off to Boot load fixed colours.
    if (enter) begin
      led_mode_d  = enter_code;
      blink_lit_d = 1'b1;
      breath_d    = '0;
      rising_d    = 1'b1;
      since_d     = '0;
      case (enter_code)
        rspg_pkg::StOff:      color_d = rspg_pkg::ColorOff;
        rspg_pkg::StOk:       color_d = rspg_pkg::ColorOk;
        rspg_pkg::StAp:       color_d = rspg_pkg::ColorAp;
        rspg_pkg::StWatering: color_d = rspg_pkg::ColorWatering;
        rspg_pkg::StFailsafe: color_d = rspg_pkg::ColorFailsafe;
        rspg_pkg::StBoot:     color_d = rspg_pkg::ColorBoot;
        default: begin
        end
      endcase
    end
  end

  // State registers advance once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_mode_q   <= rspg_pkg::StBoot;
      saved_mode_q <= rspg_pkg::StOff;
      effect_on_q  <= 1'b0;
      effect_ms_q  <= '0;
      since_q      <= '0;
      blink_lit_q  <= 1'b1;
      breath_q     <= '0;
      rising_q     <= 1'b1;
      color_q      <= rspg_pkg::ColorBoot;
    end else if (accept) begin
      led_mode_q   <= led_mode_d;
      saved_mode_q <= saved_mode_d;
      effect_on_q  <= effect_on_d;
      effect_ms_q  <= effect_ms_d;
      since_q      <= since_d;
      blink_lit_q  <= blink_lit_d;
      breath_q     <= breath_d;
      rising_q     <= rising_d;
      color_q      <= color_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.red           <= color_d.r;
      out_q.green         <= color_d.g;
      out_q.blue          <= color_d.b;
      out_q.current_state <= led_mode_d;
    end
  end

`ifndef SYNTHESIS
  // An accepted acknowledge always reports the flash state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_data_i.mode == rspg_pkg::ModeAck)
    |=> out_valid_o && (out_data_o.current_state == rspg_pkg::StAckFlash))
    else $error("acknowledge did not report the flash state");

  // While the flash runs the state code is the flash code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    effect_on_q |-> (led_mode_q == rspg_pkg::StAckFlash))
    else $error("flash running with another state code");

  // While the flash runs its timer stays below the end of the last phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    effect_on_q |-> (effect_ms_q < rspg_pkg::FlashEnd))
    else $error("flash timer ran past its end");

  // The saved state is never the flash code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    saved_mode_q <= rspg_pkg::StCritical)
    else $error("saved state out of range");
`endif

endmodule

`default_nettype wire
